@@ rtl/jtl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtl_pkg
// shared types, token kind codes and keyword tables for the json token lexer
// ----------------------------------------------------------------------------
package jtl_pkg;

  // width of the internal byte position counter (outputs keep the low 16 bits)
  localparam int unsigned PosBits = 16;
  localparam int unsigned OutBits = 16;

  // result queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrBits   = $clog2(FifoDepth);
  localparam int unsigned FillBits  = $clog2(FifoDepth + 1);

  // token kinds
  localparam logic [3:0] KindWord     = 4'd0;
  localparam logic [3:0] KindString   = 4'd1;
  localparam logic [3:0] KindTrue     = 4'd2;
  localparam logic [3:0] KindFalse    = 4'd3;
  localparam logic [3:0] KindNull     = 4'd4;
  localparam logic [3:0] KindComma    = 4'd5;
  localparam logic [3:0] KindLbrace   = 4'd6;
  localparam logic [3:0] KindRbrace   = 4'd7;
  localparam logic [3:0] KindLbracket = 4'd8;
  localparam logic [3:0] KindRbracket = 4'd9;
  localparam logic [3:0] KindColon    = 4'd10;

  // characters
  localparam logic [7:0] ChComma    = 8'h2C;
  localparam logic [7:0] ChLbrace   = 8'h7B;
  localparam logic [7:0] ChRbrace   = 8'h7D;
  localparam logic [7:0] ChLbracket = 8'h5B;
  localparam logic [7:0] ChRbracket = 8'h5D;
  localparam logic [7:0] ChColon    = 8'h3A;
  localparam logic [7:0] ChQuote    = 8'h22;

  // keyword slots in the match vector
  localparam logic [1:0] KwTrue  = 2'd0;
  localparam logic [1:0] KwFalse = 2'd1;
  localparam logic [1:0] KwNull  = 2'd2;

  typedef struct packed {
    logic [3:0]         kind;
    logic [OutBits-1:0] start_pos;
    logic [OutBits-1:0] end_pos;
    logic [OutBits-1:0] number;
    logic               last;
  } token_t;

  // expected character of a keyword at a given offset
  function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (kw)
      KwTrue: begin
        case (idx)
          3'd0:    ch = "t";
          3'd1:    ch = "r";
          3'd2:    ch = "u";
          3'd3:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      KwFalse: begin
        case (idx)
          3'd0:    ch = "f";
          3'd1:    ch = "a";
          3'd2:    ch = "l";
          3'd3:    ch = "s";
          3'd4:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      KwNull: begin
        case (idx)
          3'd0:    ch = "n";
          3'd1:    ch = "u";
          3'd2:    ch = "l";
          3'd3:    ch = "l";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] kw);
    logic [2:0] len;
    unique case (kw)
      KwFalse: len = 3'd5;
      KwTrue,
      KwNull:  len = 3'd4;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

endpackage

@@ rtl/json_token_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_token_lexer
// streaming json tokenizer: one text byte in, up to two tokens out
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+---------------------------------------
//  text    | in        | in_valid_i / in_stall_o      | text_byte_i, final_byte_i
//  token   | out       | out_valid_o / out_stall_i    | token_kind_o, token_start_o,
//          |           |                              | token_end_o, token_number_o, run_last_o
//
//  - one text byte is taken per cycle while in_stall_o is low; the lexer state updates in the same cycle
//  - a byte makes zero, one or two tokens, written into a four-entry token queue
//  - the queue sends one token per cycle while out_stall_i is low, so a byte that makes two
//    tokens needs a transfer for each; sustained rate is one byte per cycle while tokens keep up
//  - in_stall_o rises when the queue has fewer than two free entries
//  - reset clears the lexer state and empties the queue; a final byte returns the
//    lexer to its reset state so the next byte opens a new document
//
module json_token_lexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // text transfer
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        final_byte_i,
  // token transfer
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [15:0] token_start_o,
  output logic [15:0] token_end_o,
  output logic [15:0] token_number_o,
  output logic        run_last_o
);

  localparam logic [jtl_pkg::PosBits-1:0] PosMax = {jtl_pkg::PosBits{1'b1}};
  localparam logic [jtl_pkg::OutBits-1:0] CntMax = {jtl_pkg::OutBits{1'b1}};

  typedef enum logic [1:0] {
    ModeIdle   = 2'd0,
    ModeWord   = 2'd1,
    ModeString = 2'd2
  } mode_e;

  // lexer state
  mode_e                         mode_q, mode_d;
  logic [jtl_pkg::PosBits-1:0]   run_begin_q, run_begin_d;
  logic [jtl_pkg::PosBits-1:0]   pos_q, pos_d;
  logic [2:0]                    len_q, len_d;
  logic [2:0]                    alive_q, alive_d;
  logic [jtl_pkg::OutBits-1:0]   cnt_q, cnt_d;

  // token queue
  jtl_pkg::token_t               fifo_q [jtl_pkg::FifoDepth];
  logic [jtl_pkg::PtrBits-1:0]   rd_ptr_q, wr_ptr_q;
  logic [jtl_pkg::FillBits-1:0]  fill_q, fill_d;

  logic in_xfer, out_xfer;

  assign in_stall_o  = fill_q > jtl_pkg::FillBits'(jtl_pkg::FifoDepth - 2);
  assign out_valid_o = fill_q != '0;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_o && !out_stall_i;

  // --------------------------------------------------------------------------
  // byte classification and token generation
  // --------------------------------------------------------------------------
  logic [jtl_pkg::PosBits-1:0] pos_next;
  logic                        alnum, quote, punct;
  logic [3:0]                  punct_kind;
  logic                        in_word, word_start;
  logic [2:0]                  wc_len, wc_alive, new_alive, new_len;
  logic [jtl_pkg::PosBits-1:0] word_begin;

  // first-slot token (string close or word ended mid text) and second-slot token
  logic                        emit_a, emit_b;
  logic [3:0]                  kind_a, kind_b;
  logic [jtl_pkg::PosBits-1:0] start_a, end_a, start_b, end_b;
  logic [1:0]                  n_tok;
  jtl_pkg::token_t             tok_first, tok_second;
  logic [jtl_pkg::OutBits-1:0] cnt_inc1, cnt_inc2;

  function automatic logic [3:0] word_kind(input logic [2:0] alive, input logic [2:0] len);
    logic [3:0] k;
    k = jtl_pkg::KindWord;
    if (alive[jtl_pkg::KwTrue] && len == jtl_pkg::kw_len(jtl_pkg::KwTrue)) begin
      k = jtl_pkg::KindTrue;
    end
    if (alive[jtl_pkg::KwFalse] && len == jtl_pkg::kw_len(jtl_pkg::KwFalse)) begin
      k = jtl_pkg::KindFalse;
    end
    if (alive[jtl_pkg::KwNull] && len == jtl_pkg::kw_len(jtl_pkg::KwNull)) begin
      k = jtl_pkg::KindNull;
    end
    return k;
  endfunction

  function automatic logic [jtl_pkg::OutBits-1:0] cnt_sat(input logic [jtl_pkg::OutBits-1:0] v);
    return (v == CntMax) ? v : v + jtl_pkg::OutBits'(1);
  endfunction

  // position to output width (zero extends or keeps the low bits)
  function automatic logic [jtl_pkg::OutBits-1:0] OutBitsCast(
    input logic [jtl_pkg::PosBits-1:0] p
  );
    return jtl_pkg::OutBits'(p);
  endfunction

  always_comb begin
    pos_next = (pos_q == PosMax) ? pos_q : pos_q + jtl_pkg::PosBits'(1);
    alnum    = jtl_pkg::is_alnum(text_byte_i);
    quote    = text_byte_i == jtl_pkg::ChQuote;

    punct      = 1'b1;
    punct_kind = jtl_pkg::KindComma;
    case (text_byte_i)
      jtl_pkg::ChComma:    punct_kind = jtl_pkg::KindComma;
      jtl_pkg::ChLbrace:   punct_kind = jtl_pkg::KindLbrace;
      jtl_pkg::ChRbrace:   punct_kind = jtl_pkg::KindRbrace;
      jtl_pkg::ChLbracket: punct_kind = jtl_pkg::KindLbracket;
      jtl_pkg::ChRbracket: punct_kind = jtl_pkg::KindRbracket;
      jtl_pkg::ChColon:    punct_kind = jtl_pkg::KindColon;
      default:             punct      = 1'b0;
    endcase

    in_word    = mode_q == ModeWord;
    word_start = !in_word && alnum;

    // keyword match update for an alnum byte
    wc_len   = word_start ? 3'd0 : len_q;
    wc_alive = word_start ? 3'b111 : alive_q;
    for (int k = 0; k < 3; k++) begin
      new_alive[k] = wc_alive[k] && (wc_len < jtl_pkg::kw_len(2'(k)))
                     && (jtl_pkg::kw_char(2'(k), wc_len) == text_byte_i);
    end
    new_len    = (wc_len == 3'd7) ? wc_len : wc_len + 3'd1;
    word_begin = word_start ? pos_q : run_begin_q;

    mode_d      = mode_q;
    run_begin_d = run_begin_q;
    len_d       = len_q;
    alive_d     = alive_q;

    emit_a  = 1'b0;
    kind_a  = jtl_pkg::KindString;
    start_a = run_begin_q;
    end_a   = pos_q;
    emit_b  = 1'b0;
    kind_b  = punct_kind;
    start_b = pos_q;
    end_b   = pos_next;

    unique case (mode_q)
      ModeString: begin
        if (quote) begin
          emit_a = 1'b1;
          mode_d = ModeIdle;
        end else if (final_byte_i) begin
          emit_a = 1'b1;
          end_a  = pos_next;
          mode_d = ModeIdle;
        end
      end
      default: begin
        // word ended by a non-alnum byte
        if (in_word && !alnum) begin
          emit_a = 1'b1;
          kind_a = word_kind(alive_q, len_q);
          mode_d = ModeIdle;
        end else if (!in_word) begin
          mode_d = ModeIdle;
        end
        if (alnum) begin
          mode_d      = ModeWord;
          run_begin_d = word_begin;
          len_d       = new_len;
          alive_d     = new_alive;
          if (final_byte_i) begin
            emit_b  = 1'b1;
            kind_b  = word_kind(new_alive, new_len);
            start_b = word_begin;
          end
        end else if (punct) begin
          emit_b = 1'b1;
        end else if (quote) begin
          if (final_byte_i) begin
            emit_b  = 1'b1;
            kind_b  = jtl_pkg::KindString;
            start_b = pos_next;
          end else begin
            mode_d      = ModeString;
            run_begin_d = pos_next;
          end
        end
      end
    endcase

    n_tok    = {1'b0, emit_a} + {1'b0, emit_b};
    cnt_inc1 = cnt_sat(cnt_q);
    cnt_inc2 = cnt_sat(cnt_inc1);

    tok_first.kind      = emit_a ? kind_a : kind_b;
    tok_first.start_pos = OutBitsCast(emit_a ? start_a : start_b);
    tok_first.end_pos   = OutBitsCast(emit_a ? end_a : end_b);
    tok_first.number    = cnt_q;
    tok_first.last      = n_tok == 2'd1;

    tok_second.kind      = kind_b;
    tok_second.start_pos = OutBitsCast(start_b);
    tok_second.end_pos   = OutBitsCast(end_b);
    tok_second.number    = cnt_inc1;
    tok_second.last      = 1'b1;

    cnt_d = cnt_q;
    if (n_tok == 2'd1) begin
      cnt_d = cnt_inc1;
    end else if (n_tok == 2'd2) begin
      cnt_d = cnt_inc2;
    end

    pos_d = pos_next;

    // end of document: back to reset state
    if (final_byte_i) begin
      mode_d      = ModeIdle;
      run_begin_d = '0;
      pos_d       = '0;
      len_d       = '0;
      alive_d     = 3'b111;
      cnt_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeIdle;
      run_begin_q <= '0;
      pos_q       <= '0;
      len_q       <= '0;
      alive_q     <= 3'b111;
      cnt_q       <= '0;
    end else if (in_xfer) begin
      mode_q      <= mode_d;
      run_begin_q <= run_begin_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      alive_q     <= alive_d;
      cnt_q       <= cnt_d;
    end
  end

  // --------------------------------------------------------------------------
  // token queue
  // --------------------------------------------------------------------------
  always_comb begin
    fill_d = fill_q;
    if (in_xfer) begin
      fill_d = fill_d + jtl_pkg::FillBits'(n_tok);
    end
    if (out_xfer) begin
      fill_d = fill_d - jtl_pkg::FillBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (out_xfer) begin
        rd_ptr_q <= rd_ptr_q + jtl_pkg::PtrBits'(1);
      end
      if (in_xfer) begin
        wr_ptr_q <= wr_ptr_q + jtl_pkg::PtrBits'(n_tok);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && n_tok != 2'd0) begin
      fifo_q[wr_ptr_q] <= tok_first;
    end
    if (in_xfer && n_tok == 2'd2) begin
      fifo_q[wr_ptr_q + jtl_pkg::PtrBits'(1)] <= tok_second;
    end
  end

  assign token_kind_o   = fifo_q[rd_ptr_q].kind;
  assign token_start_o  = fifo_q[rd_ptr_q].start_pos;
  assign token_end_o    = fifo_q[rd_ptr_q].end_pos;
  assign token_number_o = fifo_q[rd_ptr_q].number;
  assign run_last_o     = fifo_q[rd_ptr_q].last;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= jtl_pkg::FillBits'(jtl_pkg::FifoDepth))
    else $error("token queue overfilled");

  a_doc_end_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && final_byte_i) |=> (pos_q == '0 && cnt_q == '0 && mode_q == ModeIdle))
    else $error("state not cleared after final byte");

  a_string_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && mode_q == ModeIdle && quote && !final_byte_i) |=> mode_q == ModeString)
    else $error("opening quote did not enter string mode");

  a_ptr_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("queue pointers disagree with empty fill level");

endmodule
